### sv/vra_pkg.sv
// Shared types, constants and controller states for the value rank block.
package vra_pkg;

  localparam int MAX_VALUES = 64;
  localparam int VALUE_W    = 32;
  localparam int RANK_W     = 6;
  localparam int ADDR_W     = $clog2(MAX_VALUES);
  localparam int CNT_W      = $clog2(MAX_VALUES + 1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              rank_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PIVOT,
    ST_LATCH,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic store;     // write the accepted value if there is room
    logic pivot_rd;  // read the entry being ranked
    logic pivot_ld;  // capture it and restart the scan
    logic scan;      // step the scan over all stored entries
    logic out_ld;    // move the rank into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a rank this cycle
    logic scan_done;  // all compares for the current entry finished
    logic last_item;  // current entry is the final stored one
  } dp_status_t;

endpackage

### sv/value_rank_assign_top.sv
// Top level of the value rank block: controller plus datapath.
//
//   channel   dir  handshake            payload
//   in_       in   in_valid/in_stall    in_data  (value, last)
//   out_      out  out_valid/out_stall  out_data (rank, rank_last)
//
// Values are taken one per cycle during the load phase and written to a 64-entry store.
// After the closing value, each stored entry is ranked in turn: pivot read,
// capture, a scan (one compare per entry through the single store read port,
// plus the first read and the finish), then the output load.
// Reset (rst_n low, synchronous) clears the count, the index and scan pointers and the output valid flag.
// A stalled output holds its rank; ranking of the next entry goes on up to
// its output load, which waits for the register to free.
module value_rank_assign_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vra_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vra_pkg::out_item_t out_data
);

  vra_pkg::dp_cmd_t    cmd;
  vra_pkg::dp_status_t sts;

  vra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vra_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/vra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/vra_ctrl.sv
// Controller state machine: load phase, then pivot read, scan and output per entry.
module vra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_stall,
  input  vra_pkg::dp_status_t sts,
  output vra_pkg::dp_cmd_t    cmd
);

  vra_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign accept = in_valid && (state_r == vra_pkg::ST_LOAD);

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vra_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vra_pkg::ST_LOAD: begin
        if (accept && in_last) state_nxt = vra_pkg::ST_PIVOT;
      end
      vra_pkg::ST_PIVOT: state_nxt = vra_pkg::ST_LATCH;
      vra_pkg::ST_LATCH: state_nxt = vra_pkg::ST_SCAN;
      vra_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = vra_pkg::ST_OUT;
      end
      vra_pkg::ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.last_item ? vra_pkg::ST_LOAD : vra_pkg::ST_PIVOT;
        end
      end
      default: state_nxt = vra_pkg::ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      vra_pkg::ST_LOAD: begin
        in_stall  = 1'b0;
        cmd.store = accept;
      end
      vra_pkg::ST_PIVOT: cmd.pivot_rd = 1'b1;
      vra_pkg::ST_LATCH: cmd.pivot_ld = 1'b1;
      vra_pkg::ST_SCAN:  cmd.scan     = 1'b1;
      vra_pkg::ST_OUT:   cmd.out_ld   = sts.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  // No input transaction is taken while ranking is under way
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != vra_pkg::ST_LOAD) |-> in_stall)
    else $error("input accepted outside load phase");

  // A closing transaction always leads to the pivot read
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (state_r == vra_pkg::ST_PIVOT))
    else $error("set close did not start ranking");

  // The pivot capture always comes in the cycle right after its read
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vra_pkg::ST_LATCH) |-> ($past(state_r) == vra_pkg::ST_PIVOT))
    else $error("pivot captured without a read");

endmodule

### sv/vra_dp.sv
// Datapath: value store, pivot register, scan counter, comparator and output register.
module vra_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  vra_pkg::in_item_t   in_data,
  input  vra_pkg::dp_cmd_t    cmd,
  output vra_pkg::dp_status_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output vra_pkg::out_item_t  out_data
);

  logic [vra_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [vra_pkg::ADDR_W-1:0]         idx_r, idx_nxt;
  logic [vra_pkg::CNT_W-1:0]          scan_r, scan_nxt;
  logic                               cmp_v_r, cmp_v_nxt;
  logic [vra_pkg::RANK_W-1:0]         acc_r, acc_nxt;
  logic signed [vra_pkg::VALUE_W-1:0] pivot_r, pivot_nxt;
  logic                               out_valid_r, out_valid_nxt;
  vra_pkg::out_item_t                 out_r, out_nxt;

  logic                               room;
  logic                               ram_we;
  logic [vra_pkg::ADDR_W-1:0]         ram_raddr;
  logic [vra_pkg::VALUE_W-1:0]        ram_rdata;
  logic                               smaller;

  assign room   = (count_r < vra_pkg::CNT_W'(vra_pkg::MAX_VALUES));
  assign ram_we = cmd.store && room;
  assign ram_raddr = cmd.pivot_rd ? idx_r : scan_r[vra_pkg::ADDR_W-1:0];
  assign smaller = ($signed(ram_rdata) < pivot_r);

  vra_ram #(
    .WIDTH(vra_pkg::VALUE_W),
    .DEPTH(vra_pkg::MAX_VALUES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[vra_pkg::ADDR_W-1:0]),
    .wdata (in_data.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status back to the controller
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.scan_done = (scan_r == count_r) && !cmp_v_r;
  assign sts.last_item = ((vra_pkg::CNT_W'(idx_r) + 1'b1) == count_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next values for count, index, scan, compare accumulator, pivot and output register
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    scan_nxt      = scan_r;
    cmp_v_nxt     = cmp_v_r;
    acc_nxt       = acc_r;
    pivot_nxt     = pivot_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    // Drop the output transaction once taken
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (ram_we) count_nxt = count_r + 1'b1;

    if (cmd.pivot_ld) begin
      pivot_nxt = $signed(ram_rdata);
      scan_nxt  = '0;
      cmp_v_nxt = 1'b0;
      acc_nxt   = '0;
    end

    if (cmd.scan) begin
      if (cmp_v_r && smaller) acc_nxt = acc_r + 1'b1;
      if (scan_r != count_r) begin
        scan_nxt  = scan_r + 1'b1;
        cmp_v_nxt = 1'b1;
      end else begin
        cmp_v_nxt = 1'b0;
      end
    end

    // Hand the rank to the output register and move to the next entry, or clear index and count after the last
    if (cmd.out_ld) begin
      out_valid_nxt     = 1'b1;
      out_nxt.rank      = acc_r;
      out_nxt.rank_last = sts.last_item;
      if (sts.last_item) begin
        idx_nxt   = '0;
        count_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      scan_r      <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      scan_r      <= scan_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    pivot_r <= pivot_nxt;
    out_r   <= out_nxt;
  end

  // Stored count never passes the store depth
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= vra_pkg::CNT_W'(vra_pkg::MAX_VALUES))
    else $error("value count overflow");

  // Scan pointer never passes the stored count while scanning
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (scan_r <= count_r))
    else $error("scan past stored values");

  // A rank is loaded only when the output register is free
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("output register overwritten");

  // A compare is pending only right after a scan step
  assert property (@(posedge clk) disable iff (!rst_n)
    cmp_v_r |-> $past(cmd.scan))
    else $error("compare without a scan read");

endmodule
